FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the string hash unit.
// Each macro builds one labeled concurrent assertion on a clock and an
// active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

FILE: rtl/core/tsh_pkg.sv
// ----------------------------------------------------------------------------
// tsh_pkg
// Types, constants and helpers of the table-driven string hash unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsh_pkg;

	// Field widths
	localparam int CH_W   = 8;
	localparam int HASH_W = 32;
	localparam int OFF_W  = 11;
	localparam int IDX_W  = OFF_W + 1;

	// Crypt table
	localparam int STD_WORDS     = 1280;
	localparam int TABLE_DEPTH_D = 1280;
	localparam int COLS          = 256;
	localparam int ROWS          = 5;
	localparam int COL_W         = 8;
	localparam int ROW_W         = 3;
	localparam int FILL_AW       = COL_W + ROW_W;

	// Table generator: gen = (gen * 125 + 3) mod 0x2AAAAB
	localparam int GEN_W       = 22;
	localparam int GEN_INIT    = 32'h0010_0001;
	localparam int GEN_MOD     = 32'h002A_AAAB;
	localparam int LCG_MUL     = 125;
	localparam int LCG_INC     = 3;
	localparam int LCG_X_W     = 29;
	// 3 / 2^23 sits just above 1 / GEN_MOD, so the quotient estimate is high by at most one
	localparam int RECIP_MUL   = 3;
	localparam int RECIP_SHIFT = 23;
	localparam int Q_W         = LCG_X_W + 2 - RECIP_SHIFT;
	localparam int HALF_W      = 16;

	// Seeds and register reset
	localparam logic [HASH_W-1:0] SEED_ONE_INIT = 32'h7FED_7FED;
	localparam logic [HASH_W-1:0] SEED_TWO_INIT = 32'hEEEE_EEEE;
	localparam logic [HASH_W-1:0] SEED_INC      = 32'd3;
	localparam logic [OFF_W-1:0]  OFFSET_RESET  = 11'h100;

	// ASCII case folding
	localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;
	localparam logic [CH_W-1:0] CASE_DELTA = 8'h20;

	typedef enum logic [1:0] {
		FILL_MUL,
		FILL_EST,
		FILL_RED,
		FILL_DONE
	} tsh_fill_st_t;

	typedef struct packed {
		logic                     we;
		logic [FILL_AW-1:0]       addr;
		logic [HASH_W-1:0]        data;
	} tsh_wr_t;

	function automatic logic [CH_W-1:0] fold_char(input logic [CH_W-1:0] c);
		logic [CH_W-1:0] r;
		r = c;
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			r = c - CASE_DELTA;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tsh_ram.sv
// ----------------------------------------------------------------------------
// tsh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1280
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/core/tsh_fill.sv
// ----------------------------------------------------------------------------
// tsh_fill
// Generates the crypt table after reset and writes it into the table RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsh_fill (
	input  logic             clk,
	input  logic             arst_n,
	output tsh_pkg::tsh_wr_t wr,
	output logic             busy
);
	import tsh_pkg::*;

	`include "assert_macros.svh"

	tsh_fill_st_t       state_q, state_d;
	logic [GEN_W-1:0]   gen_q;
	logic [LCG_X_W-1:0] x_q;
	logic [Q_W-1:0]     qe_q;
	logic [HALF_W-1:0]  hi_q;
	logic               lo_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;

	logic [LCG_X_W-1:0] x_d;
	logic [LCG_X_W+1:0] x3;
	logic [LCG_X_W:0]   prod;
	logic [LCG_X_W:0]   diff;
	logic [LCG_X_W:0]   diff_fix;
	logic [GEN_W-1:0]   rem;
	logic               last;

	assign x_d  = LCG_X_W'(gen_q) * LCG_X_W'(LCG_MUL) + LCG_X_W'(LCG_INC);
	assign x3   = (LCG_X_W + 2)'(x_q) * (LCG_X_W + 2)'(RECIP_MUL);
	assign prod = (LCG_X_W + 1)'(qe_q) * (LCG_X_W + 1)'(GEN_MOD);
	assign diff = {1'b0, x_q} - prod;
	// estimate one too high: add the modulus back
	assign diff_fix = diff[LCG_X_W] ? diff + (LCG_X_W + 1)'(GEN_MOD) : diff;
	assign rem      = diff_fix[GEN_W-1:0];

	assign last = lo_q && (col_q == COL_W'(COLS - 1)) && (row_q == ROW_W'(ROWS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			FILL_MUL:  state_d = FILL_EST;
			FILL_EST:  state_d = FILL_RED;
			FILL_RED:  state_d = last ? FILL_DONE : FILL_MUL;
			FILL_DONE: state_d = FILL_DONE;
			default:   state_d = FILL_DONE;
		endcase
	end

	always_comb begin
		wr.we   = 1'b0;
		wr.addr = {row_q, col_q};
		wr.data = {hi_q, rem[HALF_W-1:0]};
		busy    = 1'b1;
		case (state_q)
			FILL_RED:  wr.we = lo_q;
			FILL_DONE: busy = 1'b0;
			default:   wr.we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FILL_MUL;
			gen_q   <= GEN_W'(GEN_INIT);
			lo_q    <= 1'b0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FILL_RED) begin
				gen_q <= rem;
				lo_q  <= !lo_q;
				if (lo_q) begin
					// row is the inner loop, column the outer
					if (row_q == ROW_W'(ROWS - 1)) begin
						row_q <= '0;
						col_q <= col_q + COL_W'(1);
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FILL_MUL) begin
			x_q <= x_d;
		end
		if (state_q == FILL_EST) begin
			qe_q <= x3[LCG_X_W+1:RECIP_SHIFT];
		end
		if (state_q == FILL_RED && !lo_q) begin
			hi_q <= rem[HALF_W-1:0];
		end
	end

	`ASSERT_IMPLIES(a_wr_in_range, clk, arst_n, wr.we, wr.addr < FILL_AW'(STD_WORDS))
	`ASSERT_IMPLIES(a_done_sticky, clk, arst_n, $past(state_q) == FILL_DONE, state_q == FILL_DONE)

endmodule

`default_nettype wire

FILE: rtl/core/tsh_outq.sv
// ----------------------------------------------------------------------------
// tsh_outq
// Two-entry result queue that decouples the hash pipeline from the sink.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsh_outq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic [tsh_pkg::HASH_W-1:0] push_data,
	input  logic                      stall,
	output logic                      valid,
	output logic [tsh_pkg::HASH_W-1:0] data,
	output logic [1:0]                cnt
);
	import tsh_pkg::*;

	logic [1:0]        cnt_q;
	logic [HASH_W-1:0] head_q;
	logic [HASH_W-1:0] tail_q;
	logic              pop;

	assign valid = (cnt_q != 2'd0);
	assign data  = head_q;
	assign cnt   = cnt_q;
	assign pop   = valid && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		case (cnt_q)
			2'd0: begin
				if (push) head_q <= push_data;
			end
			2'd1: begin
				if (push && pop) head_q <= push_data;
				else if (push) tail_q <= push_data;
			end
			2'd2: begin
				if (pop) begin
					head_q <= tail_q;
					if (push) tail_q <= push_data;
				end
			end
			default: begin
				head_q <= head_q;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/table_string_hash_unit.sv
// ----------------------------------------------------------------------------
// table_string_hash_unit
// Streaming table-driven string hash: one key byte per beat in, one 32-bit
// hash out for each terminating zero byte.
//
//   channel  direction  signals                   beat
//   key      in         in_valid/in_stall         key_char, one byte
//   hash     out        out_valid/out_stall       hash_value, on zero byte
//   config   in         cfg_wr_en                 cfg_wr_data, table offset
//
// One byte per cycle sustained while in_stall is low; the seed update is
// combinational into the seed registers. A taken zero byte is registered in
// s1 with its table read, then its hash is queued and shows on out_valid.
// After reset the crypt table is generated into RAM with in_stall high: 1280
// words, two generator steps each, each step via FILL_MUL, FILL_EST, FILL_RED.
// A two-entry result queue lets bytes keep flowing while out_stall is high;
// past the fill, in_stall rises only with both slots spoken for under out_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module table_string_hash_unit #(
	parameter int TABLE_DEPTH = tsh_pkg::TABLE_DEPTH_D
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [tsh_pkg::OFF_W-1:0]  cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [tsh_pkg::CH_W-1:0]   key_char,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [tsh_pkg::HASH_W-1:0] hash_value
);
	import tsh_pkg::*;

	`include "assert_macros.svh"

	localparam int AW = $clog2(TABLE_DEPTH);

	tsh_wr_t           wr;
	logic              busy;

	logic [OFF_W-1:0]  offset_q;
	logic [HASH_W-1:0] seed_one_q;
	logic [HASH_W-1:0] seed_two_q;

	logic              valid_s1;
	logic              zero_s1;
	logic              hit_s1;
	logic [CH_W-1:0]   ch_s1;

	logic              in_acc;
	logic              key_zero;
	logic [CH_W-1:0]   ch_fold;
	logic [IDX_W-1:0]  idx;
	logic              hit;
	logic [HASH_W-1:0] rdata;
	logic [HASH_W-1:0] tbl;
	logic [HASH_W-1:0] seed_one_d;
	logic [HASH_W-1:0] seed_two_d;
	logic              s1_zero;
	logic [1:0]        q_cnt;
	logic              pop;
	logic              full;
	logic              seeds_init;

	assign key_zero = (key_char == '0);
	assign ch_fold  = fold_char(key_char);
	assign idx      = IDX_W'(offset_q) + IDX_W'(ch_fold);
	// reads past the standard table, or past the RAM, give zero
	assign hit      = (idx < IDX_W'(STD_WORDS)) && (idx < IDX_W'(TABLE_DEPTH));

	assign s1_zero  = valid_s1 && zero_s1;
	assign pop      = out_valid && !out_stall;
	assign full     = (q_cnt == 2'd2) || (q_cnt == 2'd1 && s1_zero);
	assign in_stall = busy || (full && !pop);
	assign in_acc   = in_valid && !in_stall;

	tsh_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.busy   (busy)
	);

	tsh_ram #(
		.WIDTH (HASH_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr.we),
		.waddr (AW'(wr.addr)),
		.wdata (wr.data),
		.raddr (idx[AW-1:0]),
		.rdata (rdata)
	);

	assign tbl        = hit_s1 ? rdata : '0;
	assign seed_one_d = tbl ^ (seed_one_q + seed_two_q);
	assign seed_two_d = HASH_W'(ch_s1) + seed_one_d + seed_two_q
		+ {seed_two_q[HASH_W-6:0], 5'b0} + SEED_INC;

	assign seeds_init = (seed_one_q == SEED_ONE_INIT) && (seed_two_q == SEED_TWO_INIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= OFFSET_RESET;
			seed_one_q <= SEED_ONE_INIT;
			seed_two_q <= SEED_TWO_INIT;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				offset_q <= cfg_wr_data;
			end
			valid_s1 <= in_acc;
			if (valid_s1) begin
				if (zero_s1) begin
					// end of key: reload
					seed_one_q <= SEED_ONE_INIT;
					seed_two_q <= SEED_TWO_INIT;
				end else begin
					seed_one_q <= seed_one_d;
					seed_two_q <= seed_two_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			zero_s1 <= key_zero;
			hit_s1  <= hit;
			ch_s1   <= ch_fold;
		end
	end

	tsh_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_zero),
		.push_data (seed_one_q),
		.stall     (out_stall),
		.valid     (out_valid),
		.data      (hash_value),
		.cnt       (q_cnt)
	);

	`ASSERT_IMPLIES(a_no_overflow, clk, arst_n, q_cnt == 2'd2, !s1_zero)
	`ASSERT_IMPLIES(a_hash_follows, clk, arst_n, $past(in_acc && key_zero, 2), out_valid)
	`ASSERT_NEXT(a_seed_reload, clk, arst_n, s1_zero, seeds_init)

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_string_hash_unit testbench
// Streams key bytes into the hash unit and compares every hash beat with a
// behavioral hash computed here, or with a typed value on some directed rows.
// It starts with a directed list of bytes and offsets, then runs phases of
// random keys under several table offsets. Both sides idle at random, and
// one phase holds the output back long enough to back up the input.
// ----------------------------------------------------------------------------

module testbench;

	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 60;
	localparam int N_DIRECTED   = 25;
	localparam int N_PHASES     = 10;
	localparam int PHASE_BYTES  = 45;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [tsh_pkg::OFF_W-1:0]  cfg_wr_data;
	logic                       in_valid;
	logic                       in_stall;
	logic [tsh_pkg::CH_W-1:0]   key_char;
	logic                       out_valid;
	logic                       out_stall;
	logic [tsh_pkg::HASH_W-1:0] hash_value;

	table_string_hash_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.key_char   (key_char),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value)
	);

	// Directed row: optional offset write before the byte, optional typed hash
	typedef struct packed {
		logic                       set_off;
		logic [tsh_pkg::OFF_W-1:0]  off;
		logic [tsh_pkg::CH_W-1:0]   ch;
		logic                       typed;
		logic [tsh_pkg::HASH_W-1:0] want;
	} dir_row_t;

	dir_row_t dir_rows [N_DIRECTED] = '{
		'{1'b0, 11'd0,    8'h00, 1'b1, 32'h7FED_7FED},
		'{1'b0, 11'd0,    8'h61, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'h7A, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'h00, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'h41, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'h5A, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'h00, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'h60, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'h7B, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'h40, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'h5B, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'h01, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'h7F, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'h80, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'hFF, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'h00, 1'b0, 32'h0},
		'{1'b1, 11'd0,    8'hFF, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'h00, 1'b0, 32'h0},
		'{1'b1, 11'd2047, 8'h01, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'h00, 1'b0, 32'h0},
		'{1'b1, 11'd1024, 8'hFF, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'h00, 1'b0, 32'h0},
		'{1'b1, 11'd1025, 8'hFF, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'h00, 1'b0, 32'h0},
		'{1'b0, 11'd0,    8'h00, 1'b1, 32'h7FED_7FED}
	};

	logic [tsh_pkg::HASH_W-1:0] crypt_words [0:tsh_pkg::TABLE_DEPTH_D-1];
	logic [tsh_pkg::HASH_W-1:0] seed_a;
	logic [tsh_pkg::HASH_W-1:0] seed_b;
	logic [tsh_pkg::OFF_W-1:0]  cur_off;
	logic [tsh_pkg::HASH_W-1:0] pending_hashes [$];

	int  bad_beats;
	int  cycles;
	int  gap_pct;
	bit  quiet;
	bit  hold_req;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("table_string_hash_unit test failed");
			$finish;
		end
	end

	// Fill the crypt table from the linear congruential generator, column-major
	task automatic build_crypt_words();
		longint unsigned gen;
		logic [15:0] hi;
		logic [15:0] lo;
		gen = tsh_pkg::GEN_INIT;
		for (int col = 0; col < tsh_pkg::COLS; col++) begin
			for (int row = 0; row < tsh_pkg::ROWS; row++) begin
				gen = (gen * tsh_pkg::LCG_MUL + tsh_pkg::LCG_INC) % tsh_pkg::GEN_MOD;
				hi = gen[15:0];
				gen = (gen * tsh_pkg::LCG_MUL + tsh_pkg::LCG_INC) % tsh_pkg::GEN_MOD;
				lo = gen[15:0];
				crypt_words[col + row * tsh_pkg::COLS] = {hi, lo};
			end
		end
	endtask

	// Fold one byte into the seeds; a zero byte yields the hash and reloads
	task automatic advance_hash(input logic [tsh_pkg::CH_W-1:0] ch, output bit emits,
			output logic [tsh_pkg::HASH_W-1:0] h);
		logic [tsh_pkg::CH_W-1:0]   c;
		logic [tsh_pkg::HASH_W-1:0] word;
		int                         idx;
		emits = 1'b0;
		h = '0;
		if (ch == '0) begin
			emits = 1'b1;
			h = seed_a;
			seed_a = tsh_pkg::SEED_ONE_INIT;
			seed_b = tsh_pkg::SEED_TWO_INIT;
		end else begin
			c = ch;
			if (c >= tsh_pkg::CH_LOWER_A && c <= tsh_pkg::CH_LOWER_Z) begin
				c = c - tsh_pkg::CASE_DELTA;
			end
			idx = int'(cur_off) + int'(c);
			word = (idx < tsh_pkg::TABLE_DEPTH_D) ? crypt_words[idx] : '0;
			seed_a = word ^ (seed_a + seed_b);
			seed_b = {24'b0, c} + seed_a + seed_b + (seed_b << 5) + tsh_pkg::SEED_INC;
		end
	endtask

	task automatic report_bad(input string what, input logic [tsh_pkg::HASH_W-1:0] want,
			input logic [tsh_pkg::HASH_W-1:0] got);
		bad_beats++;
		if (bad_beats <= 10) begin
			$display("%0t: %s: expected hash_value %h, got %h", $realtime, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_hashes.size() == 0) begin
				report_bad("unexpected hash beat", '0, hash_value);
			end else if (pending_hashes[0] !== hash_value) begin
				report_bad("hash mismatch", pending_hashes[0], hash_value);
				void'(pending_hashes.pop_front());
			end else begin
				void'(pending_hashes.pop_front());
			end
		end
	end

	// Output side: random short stalls, or one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				out_stall = 1'b0;
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(0, 2)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	task automatic idle_in(input int n);
		@(negedge clk);
		in_valid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Offer one byte, hold it until taken, then record its hash if any
	task automatic put_byte(input logic [tsh_pkg::CH_W-1:0] ch, input bit typed,
			input logic [tsh_pkg::HASH_W-1:0] want);
		bit                         emits;
		logic [tsh_pkg::HASH_W-1:0] h;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			idle_in($urandom_range(1, 3));
		end
		@(negedge clk);
		in_valid = 1'b1;
		key_char = ch;
		do @(posedge clk); while (in_stall);
		advance_hash(ch, emits, h);
		if (emits) begin
			pending_hashes.push_back(typed ? want : h);
		end
	endtask

	// Drain, let in-flight bytes settle, then write the offset
	task automatic write_offset(input logic [tsh_pkg::OFF_W-1:0] v);
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_hashes.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cur_off = v;
	endtask

	function automatic logic [tsh_pkg::CH_W-1:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			return tsh_pkg::CH_LOWER_A + 8'($urandom_range(0, 25));
		end else if (r < 60) begin
			return 8'h41 + 8'($urandom_range(0, 25));
		end else if (r < 75) begin
			return 8'h20 + 8'($urandom_range(0, 31));
		end
		return 8'($urandom_range(1, 255));
	endfunction

	initial begin
		logic [tsh_pkg::OFF_W-1:0] phase_off [N_PHASES];
		int                        sent;
		int                        len;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		key_char = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		bad_beats = 0;
		cycles = 0;
		gap_pct = 30;
		build_crypt_words();
		seed_a = tsh_pkg::SEED_ONE_INIT;
		seed_b = tsh_pkg::SEED_TWO_INIT;
		cur_off = tsh_pkg::OFFSET_RESET;
		phase_off = '{11'h050, 11'h100, 11'h150, 11'h200, 11'h250, 11'h300,
			11'd0, 11'd2047, 11'd1024, 11'($urandom_range(0, 2047))};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].set_off) begin
				write_offset(dir_rows[i].off);
			end
			put_byte(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			write_offset(phase_off[p]);
			gap_pct = $urandom_range(0, 40);
			quiet = (p == N_PHASES - 1);
			if (p == 1) begin
				@(posedge clk);
				hold_req = 1'b1;
			end
			sent = 0;
			while (sent < PHASE_BYTES) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: any byte, zero included
					put_byte(8'($urandom_range(0, 255)), 1'b0, '0);
					sent++;
				end else begin
					if (p == 1) begin
						len = $urandom_range(0, 2);
					end else if ($urandom_range(0, 7) == 0) begin
						len = $urandom_range(9, 24);
					end else begin
						len = $urandom_range(0, 8);
					end
					// a phase may end inside a key; the seeds carry over
					for (int k = 0; k < len && sent < PHASE_BYTES; k++) begin
						put_byte(pick_char(), 1'b0, '0);
						sent++;
					end
					if (sent < PHASE_BYTES) begin
						put_byte('0, 1'b0, '0);
						sent++;
					end
				end
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_hashes.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (bad_beats == 0) begin
			$display("table_string_hash_unit test passed");
		end else begin
			$display("table_string_hash_unit test failed");
		end
		$finish;
	end

endmodule

FILE: table_string_hash_unit.f
+incdir+rtl/core
rtl/core/tsh_pkg.sv
rtl/core/tsh_ram.sv
rtl/core/tsh_fill.sv
rtl/core/tsh_outq.sv
rtl/core/table_string_hash_unit.sv
dv/testbench.sv
